### sv/gsm_pkg.sv
package gsm_pkg;

  localparam int MAX_DIM   = 1024;
  localparam int DIM_W     = 11;
  localparam int COORD_W   = 10;
  localparam int VALUE_W   = 32;
  localparam int IMAGES    = 8;
  localparam int IDX_W     = 3;
  localparam int TDATA_W   = 56;
  localparam int PAYLOAD_W = 2 * COORD_W + VALUE_W;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  typedef enum logic [1:0] {
    MODE_COPY = 2'd0,
    MODE_D1   = 2'd1,
    MODE_D2   = 2'd2,
    MODE_D4   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1,
    REG_MODE = 2'd2,
    REG_NONE = 2'd3
  } reg_idx_t;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    mode_t            mode;
  } cfg_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
  } pos_t;

  // One source pixel expanded into its list of destination writes.
  typedef struct packed {
    logic                 none;
    logic [IDX_W-1:0]     last_idx;
    logic [VALUE_W-1:0]   value;
    pos_t [IMAGES-1:0]    pos;
  } img_t;

  // Dimension registers above the largest grid act as the largest grid.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] dim);
    eff_dim = (dim > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dim;
  endfunction

endpackage

### sv/gsm_cfg.sv
module gsm_cfg
  import gsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows <= DIM_W'(MAX_DIM);
      cfg.cols <= DIM_W'(MAX_DIM);
      cfg.mode <= MODE_COPY;
    end else if (wr) begin
      case (idx)
        REG_ROWS: cfg.rows <= pwdata[DIM_W-1:0];
        REG_COLS: cfg.cols <= pwdata[DIM_W-1:0];
        REG_MODE: cfg.mode <= mode_t'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROWS: prdata = PDATA_W'(cfg.rows);
      REG_COLS: prdata = PDATA_W'(cfg.cols);
      REG_MODE: prdata = PDATA_W'(cfg.mode);
      default:  prdata = '0;
    endcase
  end

endmodule

### sv/gsm_mirror.sv
module gsm_mirror
  import gsm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [TDATA_W-1:0]   s_tdata,
  input  logic                 emit_ready,
  output logic                 img_valid,
  output img_t                 img
);

  // Stage A: captured pixel.
  logic               va;
  coord_t             a_row, a_col;
  logic [VALUE_W-1:0] a_value;
  // Stage B: range checks and mirrored coordinates.
  logic               vb;
  coord_t             b_row, b_col, b_rmi, b_cmj;
  logic [VALUE_W-1:0] b_value;
  mode_t              b_mode;
  logic               b_none;
  logic [IDX_W-1:0]   b_last;
  // Stage C is the image list itself.
  logic               vc;

  logic free_a, free_b, free_c;

  logic [DIM_W-1:0] nr, nc, hr, hc, i_w, j_w, rmi_w, cmj_w;
  logic             on_grid, none_next;
  logic [IDX_W-1:0] last_next;
  pos_t [IMAGES-1:0] pos_next;

  assign free_c    = !vc || img.none || emit_ready;
  assign free_b    = !vb || free_c;
  assign free_a    = !va || free_b;
  assign s_tready  = free_a;
  assign img_valid = vc && !img.none;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (free_a) va <= s_tvalid;
      if (free_b) vb <= va;
      if (free_c) vc <= vb;
    end
  end

  // Stage B arithmetic.
  always_comb begin
    nr      = eff_dim(cfg.rows);
    nc      = eff_dim(cfg.cols);
    hr      = DIM_W'(({1'b0, nr} + (DIM_W+1)'(1)) >> 1);
    hc      = DIM_W'(({1'b0, nc} + (DIM_W+1)'(1)) >> 1);
    i_w     = DIM_W'(a_row);
    j_w     = DIM_W'(a_col);
    rmi_w   = nr - DIM_W'(1) - i_w;
    cmj_w   = nc - DIM_W'(1) - j_w;
    on_grid = (i_w < nr) && (j_w < nc);
    none_next = 1'b1;
    last_next = '0;
    case (cfg.mode)
      MODE_COPY: begin
        none_next = !on_grid;
        last_next = IDX_W'(0);
      end
      MODE_D1: begin
        none_next = !(on_grid && i_w < hr);
        last_next = IDX_W'(1);
      end
      MODE_D2: begin
        none_next = !(on_grid && i_w < hr && j_w < hc);
        last_next = IDX_W'(3);
      end
      MODE_D4: begin
        none_next = !(on_grid && nr == nc && i_w < hr && j_w >= i_w && j_w < hr);
        last_next = IDX_W'(7);
      end
      default: ;
    endcase
  end

  // Stage C ordering of the writes; a square grid makes nc - 1 - j equal to N - 1 - j.
  always_comb begin
    for (int k = 0; k < IMAGES; k++) begin
      pos_next[k] = '{row: b_row, col: b_col};
    end
    case (b_mode)
      MODE_D1: begin
        pos_next[1] = '{row: b_rmi, col: b_col};
      end
      MODE_D2: begin
        pos_next[1] = '{row: b_rmi, col: b_col};
        pos_next[2] = '{row: b_row, col: b_cmj};
        pos_next[3] = '{row: b_rmi, col: b_cmj};
      end
      MODE_D4: begin
        pos_next[1] = '{row: b_col, col: b_row};
        pos_next[2] = '{row: b_cmj, col: b_row};
        pos_next[3] = '{row: b_row, col: b_cmj};
        pos_next[4] = '{row: b_rmi, col: b_cmj};
        pos_next[5] = '{row: b_cmj, col: b_rmi};
        pos_next[6] = '{row: b_rmi, col: b_col};
        pos_next[7] = '{row: b_col, col: b_rmi};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (free_a) begin
      a_row   <= s_tdata[COORD_W-1:0];
      a_col   <= s_tdata[2*COORD_W-1:COORD_W];
      a_value <= s_tdata[PAYLOAD_W-1:2*COORD_W];
    end
    if (free_b) begin
      b_row   <= a_row;
      b_col   <= a_col;
      b_rmi   <= rmi_w[COORD_W-1:0];
      b_cmj   <= cmj_w[COORD_W-1:0];
      b_value <= a_value;
      b_mode  <= cfg.mode;
      b_none  <= none_next;
      b_last  <= last_next;
    end
    if (free_c) begin
      img.none     <= b_none;
      img.last_idx <= b_last;
      img.value    <= b_value;
      img.pos      <= pos_next;
    end
  end

endmodule

### sv/gsm_emit.sv
module gsm_emit
  import gsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               img_valid,
  input  img_t               img,
  output logic               emit_ready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tlast
);

  img_t             cur;
  logic [IDX_W-1:0] k;
  logic             fin;

  assign fin        = (k == cur.last_idx);
  // A new list is taken when the holding register is empty or its final write leaves.
  assign emit_ready = !m_tvalid || (m_tready && fin);
  assign m_tlast    = fin;
  assign m_tdata    = {(TDATA_W-PAYLOAD_W)'(0), cur.value, cur.pos[k].col, cur.pos[k].row};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      k        <= '0;
    end else if (emit_ready) begin
      m_tvalid <= img_valid;
      k        <= '0;
    end else if (m_tready) begin
      k <= k + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready) cur <= img;
  end

endmodule

### sv/grid_symmetry_mirror_writer.sv
// Channel   Role     Request fields
// s_*       in       s_tdata: src_row, src_col, pixel_value
// m_*       out      m_tdata: dst_row, dst_col, dst_value; m_tlast: last_write
// apb       config   grid_rows @0x0, grid_cols @0x4, symmetry_mode @0x8
//
// A pixel passes three register stages before its writes reach the output register.
// Writes leave one per cycle while m_tready is high; a pixel makes 1, 2, 4 or 8 writes
// (copy, D1, D2, D4); pixels that cause no write are dropped at one per cycle.
// Reset is synchronous and clears the valid bits and sets the config registers to their defaults.
// A stall on m_tready holds the stages behind a pending write; nothing is lost or repeated.
module grid_symmetry_mirror_writer
  import gsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // [9:0] src_row, [19:10] src_col, [51:20] pixel_value
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [9:0] dst_row, [19:10] dst_col, [51:20] dst_value
  output logic               m_tlast,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t cfg;
  img_t img;
  logic img_valid;
  logic emit_ready;

  gsm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gsm_mirror u_mirror (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .emit_ready (emit_ready),
    .img_valid  (img_valid),
    .img        (img)
  );

  gsm_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .img_valid  (img_valid),
    .img        (img),
    .emit_ready (emit_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

### sv/gsm_check.sv
module gsm_check
  import gsm_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tlast
);

  // Backpressure on the input only ever comes from a write waiting at the output.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no write pending");

  // A pixel's writes run without a gap until the one marked last.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("write run broken before last write");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled write changed");

endmodule

bind grid_symmetry_mirror_writer gsm_check u_check (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
